/* hdl/nffl_pkg.sv */
// Package: shared types, constants and codes for the next-fit free-list allocator
`timescale 1ns / 1ps
package nffl_pkg;

  localparam int unsigned HeapUnits  = 16384;
  localparam int unsigned UnitBytes  = 8;
  localparam int unsigned AddrW      = 14;
  localparam int unsigned SizeW      = 15;
  localparam int unsigned BytesW     = 18;
  localparam int unsigned ShiftBytes = $clog2(UnitBytes);
  localparam int unsigned WalkW      = 16;
  localparam logic [WalkW-1:0] WalkLimit = WalkW'(HeapUnits + 2);
  localparam logic [SizeW-1:0] GrowReset = SizeW'(1024);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_EARLY   = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [BytesW-1:0] size_bytes;
    logic [AddrW-1:0]  block_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] data_addr;
  } rsp_t;

  // One header word: link then size
  typedef struct packed {
    logic [AddrW-1:0] link;
    logic [SizeW-1:0] size;
  } hdr_t;

  // Memory port request from the sequencer
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [AddrW-1:0] addr;
    hdr_t             wdata;
  } mem_req_t;

endpackage

/* hdl/next_fit_free_list_allocator_core.sv */
// Top level: next-fit free-list allocator core
// Allocate: walk from the rover to the first fit; a split also writes a tail header.
//   On a full lap the arena grows and the new block is inserted before the walk resumes.
// Free: address-ordered insertion walk with merging; an early or ignored free skips the walk.
// Throughput: one request at a time, the next taken in the cycle after the result leaves.
// Reset: rover 0, list not started, break 1, grow minimum 1024; header store not cleared.
`timescale 1ns / 1ps
module next_fit_free_list_allocator_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [14:0]    cfg_wdata_i,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  nffl_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output nffl_pkg::rsp_t rsp_o
);
  import nffl_pkg::*;

  mem_req_t mem_req;
  hdr_t     mem_rdata;

  nffl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o),
    .mem_o      (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  nffl_hdr_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

endmodule

/* hdl/nffl_hdr_ram.sv */
// Header store: single-port RAM, one header per unit, registered read
`timescale 1ns / 1ps
module nffl_hdr_ram (
  input  logic              clk_i,
  input  nffl_pkg::mem_req_t req_i,
  output nffl_pkg::hdr_t    rdata_o
);
  import nffl_pkg::*;

  hdr_t mem_q [HeapUnits];

  // One access per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.addr];
    end
  end

endmodule

/* hdl/nffl_seq.sv */
// Sequencer: walks the free list with at most one header access per cycle, around a shared adder
`timescale 1ns / 1ps
module nffl_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  nffl_pkg::req_t     req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_stall_i,
  output nffl_pkg::rsp_t     rsp_o,
  output nffl_pkg::mem_req_t mem_o,
  input  nffl_pkg::hdr_t     mem_rdata_i
);
  import nffl_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_A_RD   = 19'h00002, // read link of prev
    S_A_NX   = 19'h00004, // header of prev arrives, read p
    S_A_CHK  = 19'h00008, // header of p arrives
    S_A_UL   = 19'h00010, // exact fit: write prev.link
    S_A_SP   = 19'h00020, // split: write tail header
    S_G      = 19'h00040, // grow: write new block header
    S_I_RD   = 19'h00080, // insert walk: read p
    S_I_CHK  = 19'h00100, // p header arrives
    S_I_HB   = 19'h00200, // hb arrives, read nx
    S_I_NX   = 19'h00400, // wait on nx
    S_I_WHB  = 19'h00800, // nx arrives, write hb
    S_I_WP   = 19'h01000, // write p
    S_A_GP   = 19'h02000, // after grow: read rover
    S_A_GW   = 19'h04000, // rover header arrives
    S_RSP    = 19'h08000,
    S_A_RDW  = 19'h10000, // wait on read of prev
    S_I_RDW  = 19'h20000, // wait on insert read
    S_A_SZ   = 19'h40000  // split: write shrunk size
  } state_e;

  state_e state_q, state_d;

  logic [SizeW-1:0] grow_q;
  logic [AddrW-1:0] rover_q, rover_d;
  logic             started_q, started_d;
  logic [SizeW:0]   brk_q, brk_d;

  logic [SizeW:0]   units_q, units_d;
  logic [AddrW-1:0] prev_q, prev_d, p_q, p_d, hb_q, hb_d;
  hdr_t             ph_q, ph_d, hbh_q, hbh_d;
  logic [WalkW-1:0] n_q, n_d;
  logic [WalkW-1:0] m_q, m_d;
  logic             ins_grow_q, ins_grow_d;
  rsp_t             rsp_q, rsp_d;

  // Shared adder, one add per cycle
  logic [SizeW:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  logic [BytesW:0] bytes_ru;
  assign bytes_ru = {1'b0, req_i.size_bytes} + (BytesW+1)'(UnitBytes - 1);

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
  assign rsp_o       = rsp_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grow_q <= GrowReset;
    end else if (cfg_we_i) begin
      grow_q <= cfg_wdata_i;
    end
  end

  // Control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rover_q    <= '0;
      started_q  <= 1'b0;
      brk_q      <= (SizeW+1)'(1);
      ins_grow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rover_q    <= rover_d;
      started_q  <= started_d;
      brk_q      <= brk_d;
      ins_grow_q <= ins_grow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    units_q <= units_d;
    prev_q  <= prev_d;
    p_q     <= p_d;
    hb_q    <= hb_d;
    ph_q    <= ph_d;
    hbh_q   <= hbh_d;
    n_q     <= n_d;
    m_q     <= m_d;
    rsp_q   <= rsp_d;
  end

  logic [SizeW:0]   need;
  logic             in_gap;

  always_comb begin
    state_d    = state_q;
    rover_d    = rover_q;
    started_d  = started_q;
    brk_d      = brk_q;
    ins_grow_d = ins_grow_q;
    units_d    = units_q;
    prev_d     = prev_q;
    p_d        = p_q;
    hb_d       = hb_q;
    ph_d       = ph_q;
    hbh_d      = hbh_q;
    n_d        = n_q;
    m_d        = m_q;
    rsp_d      = rsp_q;
    mem_o      = '0;
    add_a      = '0;
    add_b      = '0;
    need       = (units_q < {1'b0, grow_q}) ? {1'b0, grow_q} : units_q;
    in_gap     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          rsp_d = '{status: ST_OK, data_addr: '0};
          n_d   = '0;
          if (req_i.req_type == REQ_FREE) begin
            ins_grow_d = 1'b0;
            hb_d       = req_i.block_addr - AddrW'(1);
            p_d        = rover_q;
            m_d        = '0;
            if (!started_q) begin
              rsp_d.status = ST_EARLY;
              state_d      = S_RSP;
            end else if (req_i.block_addr < AddrW'(2) ||
                         {2'b0, req_i.block_addr - AddrW'(1)} >= brk_q) begin
              state_d = S_RSP;
            end else begin
              state_d = S_I_RD;
            end
          end else begin
            units_d = (SizeW+1)'(bytes_ru >> ShiftBytes) + (SizeW+1)'(1);
            if (!started_q) begin
              started_d = 1'b1;
              rover_d   = '0;
              mem_o     = '{rd: 1'b0, wr: 1'b1, addr: '0, wdata: '0};
              prev_d    = '0;
            end else begin
              prev_d = rover_q;
            end
            state_d = S_A_RD;
          end
        end
      end

      // Read link of prev
      S_A_RD: begin
        mem_o.rd   = 1'b1;
        mem_o.addr = prev_q;
        state_d    = S_A_RDW;
      end
      S_A_RDW: begin
        state_d = S_A_NX;
      end
      S_A_NX: begin
        hbh_d      = mem_rdata_i;
        p_d        = mem_rdata_i.link;
        mem_o.rd   = 1'b1;
        mem_o.addr = mem_rdata_i.link;
        state_d    = S_A_CHK;
      end
      S_A_CHK: begin
        ph_d = mem_rdata_i;
        if (n_q >= WalkLimit) begin
          rsp_d.status = ST_NO_MEM;
          state_d      = S_RSP;
        end else if ({1'b0, mem_rdata_i.size} >= units_q) begin
          if ({1'b0, mem_rdata_i.size} == units_q) begin
            state_d = S_A_UL;
          end else begin
            state_d = S_A_SZ;
          end
        end else if (p_q == rover_q) begin
          // Full lap: claim from the arena
          add_a = need;
          add_b = brk_q;
          if (add_s > (SizeW+1)'(HeapUnits)) begin
            rsp_d.status = ST_NO_MEM;
            state_d      = S_RSP;
          end else begin
            state_d = S_G;
          end
        end else begin
          n_d        = n_q + WalkW'(1);
          prev_d     = p_q;
          hbh_d      = mem_rdata_i;
          p_d        = mem_rdata_i.link;
          mem_o.rd   = 1'b1;
          mem_o.addr = mem_rdata_i.link;
          state_d    = S_A_CHK;
        end
      end
      // Exact fit: unlink p, prev keeps its size
      S_A_UL: begin
        mem_o.wr        = 1'b1;
        mem_o.addr      = prev_q;
        mem_o.wdata     = '{link: ph_q.link, size: hbh_q.size};
        rover_d         = prev_q;
        rsp_d.data_addr = p_q + AddrW'(1);
        state_d         = S_RSP;
      end
      S_A_SZ: begin
        add_a       = {1'b0, ph_q.size};
        add_b       = ~units_q + (SizeW+1)'(1);
        mem_o.wr    = 1'b1;
        mem_o.addr  = p_q;
        mem_o.wdata = '{link: ph_q.link, size: add_s[SizeW-1:0]};
        ph_d.size   = add_s[SizeW-1:0];
        state_d     = S_A_SP;
      end
      // Tail header at p + rest; not written beyond the arena
      S_A_SP: begin
        add_a       = {2'b0, p_q};
        add_b       = {1'b0, ph_q.size};
        mem_o.wr    = (add_s[SizeW:AddrW] == '0);
        mem_o.addr  = add_s[AddrW-1:0];
        mem_o.wdata = '{link: '0, size: units_q[SizeW-1:0]};
        rover_d     = prev_q;
        rsp_d.data_addr = add_s[AddrW-1:0] + AddrW'(1);
        state_d     = S_RSP;
      end
      S_G: begin
        mem_o.wr    = 1'b1;
        mem_o.addr  = brk_q[AddrW-1:0];
        mem_o.wdata = '{link: '0, size: need[SizeW-1:0]};
        hb_d        = brk_q[AddrW-1:0];
        add_a       = need;
        add_b       = brk_q;
        brk_d       = add_s;
        ins_grow_d  = 1'b1;
        p_d         = rover_q;
        m_d         = '0;
        state_d     = S_I_RD;
      end

      // Insert walk
      S_I_RD: begin
        mem_o.rd   = 1'b1;
        mem_o.addr = p_q;
        state_d    = S_I_RDW;
      end
      S_I_RDW: begin
        state_d = S_I_CHK;
      end
      S_I_CHK: begin
        ph_d   = mem_rdata_i;
        in_gap = (hb_q > p_q && hb_q < mem_rdata_i.link) ||
                 (p_q >= mem_rdata_i.link && (hb_q > p_q || hb_q < mem_rdata_i.link));
        if (m_q >= WalkLimit) begin
          state_d = ins_grow_q ? S_A_GP : S_RSP;
        end else if (in_gap) begin
          mem_o.rd   = 1'b1;
          mem_o.addr = hb_q;
          state_d    = S_I_HB;
        end else begin
          m_d     = m_q + WalkW'(1);
          p_d     = mem_rdata_i.link;
          state_d = S_I_RD;
        end
      end
      S_I_HB: begin
        hbh_d      = mem_rdata_i;
        mem_o.rd   = 1'b1;
        mem_o.addr = ph_q.link;
        state_d    = S_I_NX;
      end
      S_I_NX: begin
        state_d = S_I_WHB;
      end
      // nx header on the read port; merge hb with its upper neighbour
      S_I_WHB: begin
        add_a = {2'b0, hb_q};
        add_b = {1'b0, hbh_q.size};
        if (add_s[AddrW-1:0] == ph_q.link && add_s[SizeW:AddrW] == '0) begin
          hbh_d = '{link: mem_rdata_i.link, size: hbh_q.size + mem_rdata_i.size};
        end else begin
          hbh_d = '{link: ph_q.link, size: hbh_q.size};
        end
        mem_o.wr    = 1'b1;
        mem_o.addr  = hb_q;
        mem_o.wdata = hbh_d;
        state_d     = S_I_WP;
      end
      // Merge with lower neighbour
      S_I_WP: begin
        add_a = {2'b0, p_q};
        add_b = {1'b0, ph_q.size};
        mem_o.wr   = 1'b1;
        mem_o.addr = p_q;
        if (add_s[AddrW-1:0] == hb_q && add_s[SizeW:AddrW] == '0) begin
          mem_o.wdata = '{link: hbh_q.link, size: ph_q.size + hbh_q.size};
        end else begin
          mem_o.wdata = '{link: hb_q, size: ph_q.size};
        end
        rover_d = p_q;
        state_d = ins_grow_q ? S_A_GP : S_RSP;
      end

      // After growth resume at p = rover
      S_A_GP: begin
        ins_grow_d = 1'b0;
        p_d        = rover_d;
        mem_o.rd   = 1'b1;
        mem_o.addr = rover_q;
        n_d        = n_q;
        state_d    = S_A_GW;
      end
      S_A_GW: begin
        prev_d     = p_q;
        state_d    = S_A_NX;
        n_d        = n_q + WalkW'(1);
      end

      S_RSP: begin
        if (!rsp_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* tb/tb_top.sv */
// Testbench: directed table and random allocate/free traffic against an allocator predictor
`timescale 1ns / 1ps
module tb_top;
  import nffl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [14:0] cfg_wdata_i;
  logic req_valid_i;
  logic req_stall_o;
  req_t req_i;
  logic rsp_valid_o;
  logic rsp_stall_i;
  rsp_t rsp_o;

  next_fit_free_list_allocator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: header words, roving pointer, break and grow minimum
  int unsigned hdr_link [HeapUnits];
  int unsigned hdr_size [HeapUnits];
  int unsigned rover_q;
  bit          started_q;
  int unsigned brk_q;
  int unsigned grow_min_q;

  rsp_t        pending_rsp [$];
  int unsigned live_blocks [$];
  int          fail_count = 0;
  bit          quiet = 1'b0;

  function automatic int unsigned rd_link(int unsigned i);
    return (i < HeapUnits) ? hdr_link[i] : 0;
  endfunction

  function automatic int unsigned rd_size(int unsigned i);
    return (i < HeapUnits) ? hdr_size[i] : 0;
  endfunction

  function automatic void wr_link(int unsigned i, int unsigned v);
    if (i < HeapUnits) hdr_link[i] = v & 32'h3FFF;
  endfunction

  function automatic void wr_size(int unsigned i, int unsigned v);
    if (i < HeapUnits) hdr_size[i] = v & 32'h7FFF;
  endfunction

  // Address-ordered insertion with merging on both sides
  function automatic void link_free_block(int unsigned hb);
    int unsigned p;
    int unsigned nx;
    bit found;
    p = rover_q;
    found = 1'b0;
    for (int unsigned n = 0; n < HeapUnits + 2; n++) begin
      nx = rd_link(p);
      if ((hb > p && hb < nx) || (p >= nx && (hb > p || hb < nx))) begin
        found = 1'b1;
        break;
      end
      p = nx;
    end
    if (!found) return;
    nx = rd_link(p);
    if (hb + rd_size(hb) == nx) begin
      wr_size(hb, rd_size(hb) + rd_size(nx));
      wr_link(hb, rd_link(nx));
    end else begin
      wr_link(hb, nx);
    end
    if (p + rd_size(p) == hb) begin
      wr_size(p, rd_size(p) + rd_size(hb));
      wr_link(p, rd_link(hb));
    end else begin
      wr_link(p, hb);
    end
    rover_q = p;
  endfunction

  // Bump the break; zero when the arena cannot hold the claim
  function automatic bit claim_arena(int unsigned need);
    int unsigned nu;
    int unsigned at;
    nu = (need < grow_min_q) ? grow_min_q : need;
    at = brk_q;
    if (at + nu > HeapUnits) return 1'b0;
    brk_q = at + nu;
    wr_size(at, nu);
    link_free_block(at);
    return 1'b1;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    int unsigned units;
    int unsigned prev;
    int unsigned p;
    int unsigned sz;
    int unsigned rest;
    o.status = ST_OK;
    o.data_addr = '0;
    if (r.req_type == REQ_FREE) begin
      if (!started_q) begin
        o.status = ST_EARLY;
        return o;
      end
      if (r.block_addr < 2) return o;
      if (r.block_addr - 1 >= brk_q) return o;
      link_free_block(r.block_addr - 1);
      return o;
    end
    units = (int'(r.size_bytes) + UnitBytes - 1) / UnitBytes + 1;
    if (!started_q) begin
      hdr_link[0] = 0;
      hdr_size[0] = 0;
      rover_q = 0;
      started_q = 1'b1;
    end
    prev = rover_q;
    p = rd_link(prev);
    for (int unsigned n = 0; n < HeapUnits + 2; n++) begin
      sz = rd_size(p);
      if (sz >= units) begin
        if (sz == units) begin
          wr_link(prev, rd_link(p));
        end else begin
          rest = sz - units;
          wr_size(p, rest);
          p += rest;
          wr_size(p, units);
        end
        rover_q = prev;
        o.data_addr = AddrW'(p + 1);
        return o;
      end
      if (p == rover_q) begin
        if (!claim_arena(units)) begin
          o.status = ST_NO_MEM;
          return o;
        end
        p = rover_q;
      end
      prev = p;
      p = rd_link(p);
    end
    o.status = ST_NO_MEM;
    return o;
  endfunction

  // Directed table; for config rows val is the register value
  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;
  typedef struct {
    row_kind_e kind;
    req_type_e op;
    int        val;
    int        addr;
    int        ref_row;
    bit        typed;
    status_e   st;
    int        da;
  } dir_row_t;

  localparam int NumRows = 23;
  dir_row_t dir_rows [NumRows] = '{
    '{ROW_CFG, REQ_ALLOC, 1,      0, -1, 0, ST_OK,     0}, // no slack on growth
    '{ROW_REQ, REQ_FREE,  0,      5, -1, 1, ST_EARLY,  0}, // free before any allocation
    '{ROW_REQ, REQ_ALLOC, 131048, 0, -1, 1, ST_OK,     2}, // fills up to the last unit
    '{ROW_REQ, REQ_ALLOC, 0,      0, -1, 1, ST_OK,     0}, // header only on last unit
    '{ROW_REQ, REQ_ALLOC, 0,      0, -1, 1, ST_NO_MEM, 0}, // arena exhausted
    '{ROW_REQ, REQ_ALLOC, 131072, 0, -1, 1, ST_NO_MEM, 0}, // too large
    '{ROW_REQ, REQ_FREE,  0,      0, -1, 1, ST_OK,     0}, // bad address zero
    '{ROW_REQ, REQ_FREE,  0,      1, -1, 1, ST_OK,     0}, // sentinel
    '{ROW_REQ, REQ_FREE,  0,      0,  2, 1, ST_OK,     0},
    '{ROW_CFG, REQ_ALLOC, 0,      0, -1, 0, ST_OK,     0}, // grow minimum zero
    '{ROW_REQ, REQ_ALLOC, 1,      0, -1, 0, ST_OK,     0},
    '{ROW_REQ, REQ_ALLOC, 8,      0, -1, 0, ST_OK,     0},
    '{ROW_REQ, REQ_ALLOC, 9,      0, -1, 0, ST_OK,     0},
    '{ROW_REQ, REQ_ALLOC, 65536,  0, -1, 0, ST_OK,     0},
    '{ROW_REQ, REQ_FREE,  0,      0, 11, 1, ST_OK,     0},
    '{ROW_REQ, REQ_FREE,  0,      0, 10, 1, ST_OK,     0},
    '{ROW_CFG, REQ_ALLOC, 32767,  0, -1, 0, ST_OK,     0},
    '{ROW_REQ, REQ_ALLOC, 262143, 0, -1, 1, ST_NO_MEM, 0},
    '{ROW_REQ, REQ_ALLOC, 100,    0, -1, 0, ST_OK,     0},
    '{ROW_REQ, REQ_FREE,  0,      0, 13, 1, ST_OK,     0},
    '{ROW_REQ, REQ_FREE,  0,      0, 12, 1, ST_OK,     0},
    '{ROW_REQ, REQ_FREE,  0,      0, 18, 1, ST_OK,     0},
    '{ROW_CFG, REQ_ALLOC, 1024,   0, -1, 0, ST_OK,     0}
  };
  int row_addr [NumRows];

  // Present one request and hold it until taken; predict at acceptance
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp, output rsp_t got);
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    got = serve_request(r);
    pending_rsp.push_back(typed ? typed_rsp : got);
  endtask

  task automatic drain;
    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_grow_min(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 15'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grow_min_q = v & 32'h7FFF;
  endtask

  task automatic sender_gap;
    int n;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 8);
      req_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random request: mostly allocate/free of live blocks, some bad frees
  task automatic random_request;
    req_t r;
    rsp_t got;
    int pick;
    int k;
    r.req_type = REQ_ALLOC;
    r.size_bytes = BytesW'($urandom);
    r.block_addr = AddrW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40 && live_blocks.size() != 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      r.req_type = REQ_FREE;
      r.block_addr = AddrW'(live_blocks[k]);
      live_blocks.delete(k);
    end else if (pick < 48) begin
      r.req_type = REQ_FREE;
      if (brk_q < HeapUnits - 1 && $urandom_range(0, 1) == 0)
        r.block_addr = AddrW'($urandom_range(brk_q + 1, HeapUnits - 1));
      else
        r.block_addr = AddrW'($urandom_range(0, 1));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) r.size_bytes = BytesW'($urandom_range(0, 256));
      else if (pick < 95) r.size_bytes = BytesW'($urandom_range(0, 8192));
    end
    send_request(r, 1'b0, '0, got);
    if (r.req_type == REQ_ALLOC && got.status == ST_OK && got.data_addr != 0)
      live_blocks.push_back(got.data_addr);
  endtask

  // Response side: random stall bursts, none in the quiet tail
  initial begin
    int n;
    rsp_stall_i = 1'b0;
    forever begin
      if (quiet) begin
        rsp_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 8);
        rsp_stall_i <= ($urandom_range(0, 1) == 0);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: status %0d data_addr %0d", rsp_o.status, rsp_o.data_addr);
        fail_count++;
      end else begin
        if (rsp_o.status !== pending_rsp[0].status) begin
          $error("status: expected %0d, got %0d", pending_rsp[0].status, rsp_o.status);
          fail_count++;
        end
        if (rsp_o.data_addr !== pending_rsp[0].data_addr) begin
          $error("data_addr: expected %0d, got %0d",
                 pending_rsp[0].data_addr, rsp_o.data_addr);
          fail_count++;
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  // Main sequence
  initial begin
    req_t r;
    rsp_t typed_rsp;
    rsp_t got;
    int unsigned phase_cfg [6];
    phase_cfg = '{1024, 1, 0, 32767, 16384, 64};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_valid_i = 1'b0;
    req_i = '0;
    for (int i = 0; i < HeapUnits; i++) begin
      hdr_link[i] = 0;
      hdr_size[i] = 0;
    end
    rover_q = 0;
    started_q = 1'b0;
    brk_q = 1;
    grow_min_q = GrowReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_grow_min(dir_rows[i].val);
      end else begin
        sender_gap();
        r.req_type = dir_rows[i].op;
        r.size_bytes = BytesW'(dir_rows[i].val);
        r.block_addr = (dir_rows[i].ref_row >= 0) ? AddrW'(row_addr[dir_rows[i].ref_row])
                                                  : AddrW'(dir_rows[i].addr);
        typed_rsp.status = dir_rows[i].st;
        typed_rsp.data_addr = AddrW'(dir_rows[i].da);
        send_request(r, dir_rows[i].typed, typed_rsp, got);
        row_addr[i] = got.data_addr;
      end
    end
    // sender holds off until every result is back
    drain();

    foreach (phase_cfg[ph]) begin
      write_grow_min(phase_cfg[ph]);
      if (ph == 5) quiet = 1'b1;
      repeat (75) begin
        sender_gap();
        random_request();
      end
    end

    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hdl/nffl_pkg.sv
hdl/nffl_hdr_ram.sv
hdl/nffl_seq.sv
hdl/next_fit_free_list_allocator_core.sv
tb/tb_top.sv
